// ===== rtl/asd_pkg.sv =====
package asd_pkg;

  localparam int WINDOW_DEF = 64;
  localparam int SAMPLE_W   = 16;
  localparam int HOLD_W     = 10;
  localparam int LEVEL_W    = 15;  // peak and floor never go negative

  // register map
  localparam logic REG_HOLD_STEPS = 1'b0;

  // reciprocal multipliers, exact for any 15-bit operand
  localparam int RECIP30   = 34953;  // ceil(2^20 / 30)
  localparam int SHIFT30   = 20;
  localparam int RECIP100  = 5243;   // ceil(2^19 / 100)
  localparam int SHIFT100  = 19;
  localparam int RECIP_W   = 16;

  localparam logic [LEVEL_W-1:0] FLOOR_INIT = '1;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] avg;
  } track_req_t;

  typedef struct packed {
    logic done;
    logic silent;
  } track_rsp_t;

endpackage

// ===== rtl/asd_ram.sv =====
module asd_ram #(
  parameter int DEPTH  = asd_pkg::WINDOW_DEF,
  parameter int DATA_W = asd_pkg::SAMPLE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read-first: same-address read returns the old entry
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/asd_div.sv =====
module asd_div #(
  parameter int DIVISOR    = asd_pkg::WINDOW_DEF,
  parameter int DIVIDEND_W = asd_pkg::SAMPLE_W + $clog2(asd_pkg::WINDOW_DEF)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [DIVIDEND_W-1:0]        dividend,
  output logic                                done,
  output logic signed [asd_pkg::SAMPLE_W-1:0] quotient
);
  import asd_pkg::*;

  // reciprocal multiply, exact for any magnitude below 2^DIVIDEND_W
  localparam int SHIFT = DIVIDEND_W + $clog2(DIVISOR);
  localparam int RW    = DIVIDEND_W + 1;
  localparam int PW    = DIVIDEND_W + RW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic                  stage_r, done_r, neg_r;
  logic [DIVIDEND_W-1:0] mag_r;
  logic [PW-1:0]         prod_r;
  logic [SAMPLE_W:0]     q_mag;

  // start: latch magnitude; next cycle: multiply; done holds until next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r || (done_r && !start);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVIDEND_W-1];
      mag_r <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
    end
    if (stage_r) begin
      prod_r <= PW'(mag_r) * PW'(RECIP);
    end
  end

  assign q_mag    = (SAMPLE_W+1)'(prod_r >> SHIFT);
  assign done     = done_r;
  assign quotient = neg_r ? SAMPLE_W'(-q_mag) : q_mag[SAMPLE_W-1:0];

endmodule

// ===== rtl/asd_track.sv =====
module asd_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [asd_pkg::HOLD_W-1:0]  hold_steps,
  input  asd_pkg::track_req_t         req,
  output asd_pkg::track_rsp_t         rsp
);
  import asd_pkg::*;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_M30  = 3'd1;
  localparam logic [2:0] T_F30  = 3'd2;
  localparam logic [2:0] T_F100 = 3'd3;
  localparam logic [2:0] T_DEC  = 3'd4;

  localparam int MUL_W = LEVEL_W + RECIP_W;

  logic [2:0]                state_r;
  logic signed [SAMPLE_W-1:0] avg_r;
  logic [LEVEL_W-1:0]        peak_r, floor_r;
  logic                      silent_r, prev_r;
  logic [HOLD_W-1:0]         hold_cnt_r;
  logic [MUL_W-1:0]          prod_r;

  logic signed [SAMPLE_W-1:0] peak_s, floor_s;
  logic [LEVEL_W+3:0]        floor_x10;
  logic [LEVEL_W+6:0]        floor_x100;
  logic [LEVEL_W+2:0]        ceil_x5;
  logic signed [LEVEL_W+3:0] avg_x, ceil_s;
  logic                      below;

  assign peak_s     = $signed({1'b0, peak_r});
  assign floor_s    = $signed({1'b0, floor_r});
  assign floor_x10  = (LEVEL_W+4)'(floor_r) * (LEVEL_W+4)'(10);
  assign floor_x100 = (LEVEL_W+7)'(floor_r) * (LEVEL_W+7)'(100);
  assign ceil_x5    = (LEVEL_W+3)'(floor_r) * (LEVEL_W+3)'(5);
  assign avg_x      = {{(LEVEL_W+4-SAMPLE_W){avg_r[SAMPLE_W-1]}}, avg_r};
  assign ceil_s     = $signed({1'b0, ceil_x5});
  assign below      = (avg_x < ceil_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= T_IDLE;
      peak_r     <= '0;
      floor_r    <= FLOOR_INIT;
      silent_r   <= 1'b1;
      prev_r     <= 1'b0;
      hold_cnt_r <= '0;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (req.start) begin
            prev_r <= silent_r;
            if (req.avg > peak_s) begin
              peak_r <= req.avg[LEVEL_W-1:0];
            end
            if (req.avg < floor_s && req.avg > 0) begin
              floor_r <= req.avg[LEVEL_W-1:0];
            end
            state_r <= T_M30;
          end
        end
        T_M30: state_r <= T_F30;
        T_F30: begin
          if (floor_x10 > (LEVEL_W+4)'(peak_r)) begin
            floor_r <= LEVEL_W'(prod_r >> SHIFT30);
          end
          state_r <= T_F100;
        end
        T_F100: begin
          if (floor_x100 < (LEVEL_W+7)'(peak_r)) begin
            floor_r <= LEVEL_W'(prod_r >> SHIFT100);
          end
          state_r <= T_DEC;
        end
        T_DEC: begin
          // hold off a sound-to-silence switch
          if (!prev_r && below) begin
            if (hold_cnt_r < hold_steps) begin
              hold_cnt_r <= hold_cnt_r + HOLD_W'(1);
              silent_r   <= 1'b0;
            end else begin
              hold_cnt_r <= '0;
              silent_r   <= 1'b1;
            end
          end else begin
            silent_r <= below;
          end
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && req.start) begin
      avg_r <= req.avg;
    end
    if (state_r == T_M30) begin
      prod_r <= MUL_W'(peak_r) * MUL_W'(RECIP30);
    end else if (state_r == T_F30) begin
      prod_r <= MUL_W'(peak_r) * MUL_W'(RECIP100);
    end
  end

  assign rsp.done   = (state_r == T_DEC);
  assign rsp.silent = silent_r;

endmodule

// ===== rtl/audio_silence_detector.sv =====
// Sequence: while the window is filling, an accepted request passes ST_PUSH and
//   ST_DONE; after that it also passes ST_SCAN, ST_WAIT and ST_TRACK.
// Flow: one request in flight, so a new request waits until the last result has
//   left ST_DONE; the window scan reads one entry per cycle through the single
//   memory read port. A stalled result adds its stall.
// Reset: synchronous, active low; the window is treated as all zero until it
//   has been filled once, hold_steps clears to 0.
module audio_silence_detector #(
  parameter int WINDOW = asd_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [asd_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [asd_pkg::SAMPLE_W-1:0] in_right_sample,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_is_silent,
  output logic                               out_is_started,
  output logic [asd_pkg::SAMPLE_W-1:0]        out_amplitude_range,
  output logic signed [asd_pkg::SAMPLE_W-1:0] out_window_average,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import asd_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + AW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUSH  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_TRACK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                 state_r;
  logic [AW-1:0]              ptr_r, scan_addr_r;
  logic                       started_r, scan_vld_r, div_go_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] mono_r, max_r, min_r;
  logic [HOLD_W-1:0]          hold_r;

  logic                       out_valid_r, out_silent_r, out_started_r;
  logic [SAMPLE_W-1:0]        out_range_r;
  logic signed [SAMPLE_W-1:0] out_avg_r;

  logic                       accept, slot_free, wait_go;
  logic signed [SAMPLE_W:0]   pair_sum, pair_adj;
  logic signed [SAMPLE_W-1:0] mono, old_sample, rd_sample;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [AW-1:0]              raddr;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                       cfg_wr;
  track_req_t                 trk_req;
  track_rsp_t                 trk_rsp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_HOLD_STEPS) begin
      hold_r <= pwdata[HOLD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HOLD_STEPS) ? 32'(hold_r) : 32'd0;

  // ---------------- mono mix ----------------
  // halve the channel sum with truncation toward zero
  assign pair_sum = {in_left_sample[SAMPLE_W-1], in_left_sample}
                  + {in_right_sample[SAMPLE_W-1], in_right_sample};
  assign pair_adj = pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W]);
  assign mono     = pair_adj[SAMPLE_W:1];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // ---------------- sample window memory ----------------
  // circular buffer; ptr_r points at the oldest entry. The new sample goes
  // in at ptr_r on accept while the old one is read out on the same edge.
  assign raddr = (state_r == ST_SCAN) ? scan_addr_r : ptr_r;

  asd_ram #(
    .DEPTH  (WINDOW),
    .DATA_W (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr_r),
    .wdata (mono),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign rd_sample = $signed(rd_data);
  // until the first full lap, the slot being replaced was never written: zero
  assign old_sample = started_r ? rd_sample : '0;
  assign sum_nxt = sum_r + {{AW{mono_r[SAMPLE_W-1]}}, mono_r}
                         - {{AW{old_sample[SAMPLE_W-1]}}, old_sample};

  // ---------------- window mean ----------------
  // reciprocal divide, started with the scan; ST_WAIT waits for it to finish
  asd_div #(
    .DIVISOR    (WINDOW),
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (sum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- peak / floor / hold-off ----------------
  assign wait_go       = (state_r == ST_WAIT) && !scan_vld_r && div_done;
  assign trk_req.start = wait_go;
  assign trk_req.avg   = div_q;

  asd_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_steps (hold_r),
    .req        (trk_req),
    .rsp        (trk_rsp)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      scan_addr_r <= '0;
      started_r   <= 1'b0;
      scan_vld_r  <= 1'b0;
      div_go_r    <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_vld_r <= (state_r == ST_SCAN);
      div_go_r   <= (state_r == ST_PUSH) && (started_r || ptr_r == AW'(WINDOW - 1));
      // a new result may replace one leaving on the same edge
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          sum_r <= sum_nxt;
          ptr_r <= (ptr_r == AW'(WINDOW - 1)) ? '0 : ptr_r + AW'(1);
          // before the first lap ptr_r doubles as the fill count
          if (started_r || ptr_r == AW'(WINDOW - 1)) begin
            started_r   <= 1'b1;
            scan_addr_r <= '0;
            state_r     <= ST_SCAN;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SCAN: begin
          scan_addr_r <= scan_addr_r + AW'(1);
          if (scan_addr_r == AW'(WINDOW - 1)) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (wait_go) begin
            state_r <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          if (trk_rsp.done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mono_r <= mono;
    end
    if (state_r == ST_PUSH) begin
      max_r <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      min_r <= {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (scan_vld_r) begin
      if (rd_sample > max_r) max_r <= rd_sample;
      if (rd_sample < min_r) min_r <= rd_sample;
    end
    if (state_r == ST_DONE && slot_free) begin
      out_started_r <= started_r;
      out_silent_r  <= started_r && trk_rsp.silent;
      out_range_r   <= started_r ? SAMPLE_W'(max_r - min_r) : '0;
      out_avg_r     <= started_r ? div_q : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_silent       = out_silent_r;
  assign out_is_started      = out_started_r;
  assign out_amplitude_range = out_range_r;
  assign out_window_average  = out_avg_r;

`ifndef SYNTH
  // once the window has filled it stays filled
  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");

  // results from before the window filled carry no judgment
  a_prestart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_started) |->
      (!out_is_silent && out_amplitude_range == '0 && out_window_average == '0))
    else $error("nonzero result before start");

  // every request moves the write pointer
  a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |=> (ptr_r != $past(ptr_r)))
    else $error("window pointer did not advance");

  // the tracker is only started with a finished mean and a finished scan
  a_track_start: assert property (@(posedge clk) disable iff (!rst_n)
    trk_req.start |-> (div_done && !scan_vld_r && started_r))
    else $error("tracker started early");
`endif

endmodule
